@@ rtl/ptw_pkg.sv @@
package ptw_pkg;

  localparam int unsigned VaddrWidth = 48;
  localparam int unsigned PaddrWidth = 32;
  localparam int unsigned IndexWidth = 9;
  localparam int unsigned PageShift  = 12;
  localparam int unsigned LargeShift = 21;
  localparam int unsigned PsBit      = 7;

  typedef enum logic {
    CMD_TRANSLATE = 1'b0,
    CMD_RESPONSE  = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    KIND_READ       = 2'd0,
    KIND_DONE       = 2'd1,
    KIND_UNEXPECTED = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    LEVEL_PML4 = 2'd0,
    LEVEL_PDPT = 2'd1,
    LEVEL_PD   = 2'd2,
    LEVEL_PT   = 2'd3
  } level_e;

  typedef struct packed {
    logic                  busy;
    level_e                level;
    logic [VaddrWidth-1:0] vaddr;
  } walk_state_t;

  typedef struct packed {
    kind_e                 kind;
    logic [PaddrWidth-1:0] read_addr;
    logic [PaddrWidth-1:0] phys_addr;
    logic                  large_page;
  } walk_result_t;

  function automatic logic [PaddrWidth-1:0] entry_addr(
    input logic [PaddrWidth-1:0] base,
    input logic [IndexWidth-1:0] idx
  );
    return {base[PaddrWidth-1:PageShift], idx, 3'b000};
  endfunction

endpackage

@@ rtl/ptw_step.sv @@
module ptw_step (
  input  ptw_pkg::walk_state_t            state_i,
  input  logic                            command_i,
  input  logic [ptw_pkg::VaddrWidth-1:0]  virt_addr_i,
  input  logic [ptw_pkg::PaddrWidth-1:0]  table_base_i,
  input  logic [ptw_pkg::PaddrWidth-1:0]  read_data_i,
  output ptw_pkg::walk_state_t            state_o,
  output ptw_pkg::walk_result_t           result_o
);

  logic [ptw_pkg::VaddrWidth-1:0] sv;

  assign sv = state_i.vaddr;

  always_comb begin
    state_o             = state_i;
    result_o.kind       = ptw_pkg::KIND_READ;
    result_o.read_addr  = '0;
    result_o.phys_addr  = '0;
    result_o.large_page = 1'b0;
    if (command_i == ptw_pkg::CMD_TRANSLATE) begin
      state_o.busy       = 1'b1;
      state_o.level      = ptw_pkg::LEVEL_PML4;
      state_o.vaddr      = virt_addr_i;
      result_o.read_addr = ptw_pkg::entry_addr(table_base_i, virt_addr_i[47:39]);
    end else if (!state_i.busy) begin
      result_o.kind = ptw_pkg::KIND_UNEXPECTED;
    end else begin
      unique case (state_i.level)
        ptw_pkg::LEVEL_PML4: begin
          state_o.level      = ptw_pkg::LEVEL_PDPT;
          result_o.read_addr = ptw_pkg::entry_addr(read_data_i, sv[38:30]);
        end
        ptw_pkg::LEVEL_PDPT: begin
          state_o.level      = ptw_pkg::LEVEL_PD;
          result_o.read_addr = ptw_pkg::entry_addr(read_data_i, sv[29:21]);
        end
        ptw_pkg::LEVEL_PD: begin
          if (read_data_i[ptw_pkg::PsBit]) begin
            state_o.busy        = 1'b0;
            state_o.level       = ptw_pkg::LEVEL_PML4;
            result_o.kind       = ptw_pkg::KIND_DONE;
            result_o.large_page = 1'b1;
            result_o.phys_addr  = {read_data_i[ptw_pkg::PaddrWidth-1:ptw_pkg::LargeShift],
                                   sv[ptw_pkg::LargeShift-1:0]};
          end else begin
            state_o.level      = ptw_pkg::LEVEL_PT;
            result_o.read_addr = ptw_pkg::entry_addr(read_data_i, sv[20:12]);
          end
        end
        ptw_pkg::LEVEL_PT: begin
          state_o.busy       = 1'b0;
          state_o.level      = ptw_pkg::LEVEL_PML4;
          result_o.kind      = ptw_pkg::KIND_DONE;
          result_o.phys_addr = {read_data_i[ptw_pkg::PaddrWidth-1:ptw_pkg::PageShift],
                                sv[ptw_pkg::PageShift-1:0]};
        end
        default: begin
          state_o = state_i;
        end
      endcase
    end
  end

endmodule

@@ rtl/page_table_walk_unit.sv @@
// Four-level page-table walker for 48-bit virtual addresses. A translate
// transfer (command 0) starts a walk and answers with the address of the
// first-level entry; each response transfer (command 1) carries a 32-bit
// entry and answers with the next entry address, or with the physical
// address once a 2 MiB or 4 KiB page is reached. A translate during a walk
// restarts it, and a response while idle is answered as unexpected. Every
// input transfer yields exactly one result through a single
// output register; a new input is taken every cycle while that register is
// empty or being drained, so the sustained rate is one item per cycle.
module page_table_walk_unit (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic                            command_i,
  input  logic [ptw_pkg::VaddrWidth-1:0]  virt_addr_i,
  input  logic [ptw_pkg::PaddrWidth-1:0]  table_base_i,
  input  logic [ptw_pkg::PaddrWidth-1:0]  read_data_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [1:0]                      kind_o,
  output logic [ptw_pkg::PaddrWidth-1:0]  read_addr_o,
  output logic [ptw_pkg::PaddrWidth-1:0]  phys_addr_o,
  output logic                            large_page_o
);

  ptw_pkg::walk_state_t  state_q, state_d;
  ptw_pkg::walk_result_t result_q, result_d;
  logic                  out_valid_q, out_valid_d;
  logic                  accept;

  ptw_step u_step (
    .state_i      (state_q),
    .command_i    (command_i),
    .virt_addr_i  (virt_addr_i),
    .table_base_i (table_base_i),
    .read_data_i  (read_data_i),
    .state_o      (state_d),
    .result_o     (result_d)
  );

  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign accept      = in_valid_i && in_ready_o;
  assign out_valid_d = accept ? 1'b1 : (out_valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (accept) begin
        state_q <= state_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      result_q <= result_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign kind_o       = result_q.kind;
  assign read_addr_o  = result_q.read_addr;
  assign phys_addr_o  = result_q.phys_addr;
  assign large_page_o = result_q.large_page;

endmodule

@@ tb/sv/page_table_walk_unit_test.sv @@
`timescale 1ns / 1ps

module page_table_walk_unit_test;

  localparam logic [31:0] FrameMask = 32'hFFFF_F000;
  localparam logic [31:0] LargeMask = 32'hFFE0_0000;
  localparam int StallLimit = 4000;
  localparam int HoldCycles = 300;
  localparam int DrainCycles = 4;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic command_i = 1'b0;
  logic [ptw_pkg::VaddrWidth-1:0] virt_addr_i = '0;
  logic [ptw_pkg::PaddrWidth-1:0] table_base_i = '0;
  logic [ptw_pkg::PaddrWidth-1:0] read_data_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic [1:0] kind_o;
  logic [ptw_pkg::PaddrWidth-1:0] read_addr_o;
  logic [ptw_pkg::PaddrWidth-1:0] phys_addr_o;
  logic large_page_o;

  logic walk_busy = 1'b0;
  ptw_pkg::level_e walk_level = ptw_pkg::LEVEL_PML4;
  logic [ptw_pkg::VaddrWidth-1:0] walk_vaddr = '0;

  ptw_pkg::walk_result_t pending_results[$];
  ptw_pkg::walk_result_t oldest_result;
  int items_sent = 0;
  int mismatch_count = 0;
  int tx_idle_pct = 0;
  int rx_stall_pct = 0;
  int hold_left = 0;
  int stall_cycles = 0;

  page_table_walk_unit DUT (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .command_i(command_i),
    .virt_addr_i(virt_addr_i),
    .table_base_i(table_base_i),
    .read_data_i(read_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .kind_o(kind_o),
    .read_addr_o(read_addr_o),
    .phys_addr_o(phys_addr_o),
    .large_page_o(large_page_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  function automatic logic [31:0] slot_addr(input logic [31:0] entry, input logic [8:0] idx);
    return (entry & FrameMask) + {20'd0, idx, 3'd0};
  endfunction

  function automatic logic [ptw_pkg::VaddrWidth-1:0] rand_vaddr();
    logic [63:0] word;
    word = {$urandom, $urandom};
    return word[ptw_pkg::VaddrWidth-1:0];
  endfunction

  task automatic predict_walk_step(input ptw_pkg::cmd_e cmd,
                                   input logic [ptw_pkg::VaddrWidth-1:0] va,
                                   input logic [31:0] base, input logic [31:0] entry,
                                   output ptw_pkg::walk_result_t res);
    res = '{kind: ptw_pkg::KIND_READ, read_addr: '0, phys_addr: '0, large_page: 1'b0};
    if (cmd == ptw_pkg::CMD_TRANSLATE) begin
      walk_vaddr = va;
      walk_busy = 1'b1;
      walk_level = ptw_pkg::LEVEL_PML4;
      res.read_addr = slot_addr(base, va[47:39]);
    end else if (!walk_busy) begin
      res.kind = ptw_pkg::KIND_UNEXPECTED;
    end else begin
      unique case (walk_level)
        ptw_pkg::LEVEL_PML4: begin
          walk_level = ptw_pkg::LEVEL_PDPT;
          res.read_addr = slot_addr(entry, walk_vaddr[38:30]);
        end
        ptw_pkg::LEVEL_PDPT: begin
          walk_level = ptw_pkg::LEVEL_PD;
          res.read_addr = slot_addr(entry, walk_vaddr[29:21]);
        end
        ptw_pkg::LEVEL_PD: begin
          if (entry[ptw_pkg::PsBit]) begin
            walk_busy = 1'b0;
            walk_level = ptw_pkg::LEVEL_PML4;
            res.kind = ptw_pkg::KIND_DONE;
            res.phys_addr = (entry & LargeMask) + {11'd0, walk_vaddr[20:0]};
            res.large_page = 1'b1;
          end else begin
            walk_level = ptw_pkg::LEVEL_PT;
            res.read_addr = slot_addr(entry, walk_vaddr[20:12]);
          end
        end
        ptw_pkg::LEVEL_PT: begin
          walk_busy = 1'b0;
          walk_level = ptw_pkg::LEVEL_PML4;
          res.kind = ptw_pkg::KIND_DONE;
          res.phys_addr = (entry & FrameMask) + {20'd0, walk_vaddr[11:0]};
        end
      endcase
    end
  endtask

  task automatic send_item(input ptw_pkg::cmd_e cmd,
                           input logic [ptw_pkg::VaddrWidth-1:0] va,
                           input logic [31:0] base, input logic [31:0] entry);
    ptw_pkg::walk_result_t res;
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    command_i <= cmd;
    virt_addr_i <= va;
    table_base_i <= base;
    read_data_i <= entry;
    do @(posedge clk_i); while (!in_ready_o);
    predict_walk_step(cmd, va, base, entry, res);
    pending_results.push_back(res);
    items_sent++;
  endtask

  task automatic send_translate(input logic [ptw_pkg::VaddrWidth-1:0] va,
                                input logic [31:0] base);
    send_item(ptw_pkg::CMD_TRANSLATE, va, base, $urandom);
  endtask

  task automatic send_response(input logic [31:0] entry);
    send_item(ptw_pkg::CMD_RESPONSE, rand_vaddr(), $urandom, entry);
  endtask

  task automatic set_idling(input int tx_pct, input int rx_pct);
    @(negedge clk_i);
    tx_idle_pct = tx_pct;
    rx_stall_pct = rx_pct;
    @(posedge clk_i);
  endtask

  task automatic wait_for_results();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // Mostly complete walks with random content, some cut short by a new
  // translate, plus stray responses.
  task automatic run_walks(input int count);
    int goal;
    int steps;
    logic big_page;
    logic [31:0] entry;
    goal = items_sent + count;
    while (items_sent < goal) begin
      if ($urandom_range(99) < 8) begin
        send_response($urandom);
      end else begin
        send_translate(rand_vaddr(), $urandom);
        big_page = 1'($urandom_range(1));
        steps = big_page ? 3 : 4;
        if ($urandom_range(99) < 10) steps = $urandom_range(steps - 1);
        for (int k = 0; k < steps; k++) begin
          entry = $urandom;
          if (k == 2) entry[ptw_pkg::PsBit] = big_page;
          send_response(entry);
        end
      end
    end
  endtask

  task automatic test_directed();
    set_idling(0, 0);
    send_response(32'hFFFF_FFFF);
    send_translate({ptw_pkg::VaddrWidth{1'b1}}, 32'hFFFF_FFFF);
    send_response(32'hFFFF_FFFF);
    send_response(32'hFFFF_FFFF);
    send_response(32'hFFFF_FFFF);
    send_translate('0, 32'h0);
    send_response(32'h0);
    send_response(32'h0);
    send_response(32'h0);
    send_response(32'h0);
    send_translate({ptw_pkg::VaddrWidth{1'b1}}, 32'h0000_0FFF);
    send_response(32'hFFFF_F000);
    send_response(32'h0000_0FFF);
    send_response(32'hFFFF_FF7F);
    send_response(32'hFFFF_FFFF);
    send_response(32'h1234_5678);
    send_translate(48'h8000_0000_0000, 32'h8000_0000);
    send_response(32'h0000_1000);
    send_translate(48'h7FFF_FFFF_FFFF, 32'h7FFF_F000);
    send_response(32'h8000_0000);
    send_response(32'h4000_0000);
    send_response(32'h0000_0000);
    send_translate(48'h0000_0020_1001, 32'h0001_0000);
    wait_for_results();
  endtask

  task automatic test_random_phase(input int tx_pct, input int rx_pct, input int count);
    set_idling(tx_pct, rx_pct);
    run_walks(count);
    wait_for_results();
  endtask

  task automatic test_backpressure();
    set_idling(0, 0);
    @(negedge clk_i);
    hold_left = HoldCycles;
    @(posedge clk_i);
    run_walks(60);
    wait_for_results();
  endtask

  always @(posedge clk_i) begin
    if (hold_left != 0) begin
      out_ready_i <= 1'b0;
      hold_left <= hold_left - 1;
    end else begin
      out_ready_i <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) begin
          $display("unexpected transfer: kind=%0d read_addr=%h phys_addr=%h large=%b",
                   kind_o, read_addr_o, phys_addr_o, large_page_o);
        end
      end else begin
        oldest_result = pending_results.pop_front();
        if (kind_o !== oldest_result.kind || read_addr_o !== oldest_result.read_addr ||
            phys_addr_o !== oldest_result.phys_addr ||
            large_page_o !== oldest_result.large_page) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("mismatch: expected kind=%0d read_addr=%h phys_addr=%h large=%b",
                     oldest_result.kind, oldest_result.read_addr,
                     oldest_result.phys_addr, oldest_result.large_page);
            $display("          actual   kind=%0d read_addr=%h phys_addr=%h large=%b",
                     kind_o, read_addr_o, phys_addr_o, large_page_o);
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= StallLimit) begin
      $display("end of test: mismatches");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random_phase(0, 0, 400);
    test_random_phase(73, 0, 400);
    test_random_phase(0, 73, 400);
    test_random_phase(11, 11, 400);
    test_backpressure();
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

@@ page_table_walk_unit.f @@
rtl/ptw_pkg.sv
rtl/ptw_step.sv
rtl/page_table_walk_unit.sv
tb/sv/page_table_walk_unit_test.sv
